// File: rtl/kes_pkg.sv
`timescale 1ns / 1ps
// Shared types, fixed-point constants and table builders for the Kepler solver.
package kes_pkg;

  // Field and datapath widths.
  localparam int ECC_W      = 30;
  localparam int MA_W       = 32;
  localparam int ANG_W      = 39;
  localparam int ITER_W     = 6;
  localparam int TOL_W      = 16;
  localparam int RED_W      = 40;
  localparam int MUL_A_W    = 40;
  localparam int MUL_B_W    = 32;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int TRIG_W     = 32;
  localparam int XY_W       = 43;
  localparam int Z_W        = 64;
  localparam int ED_W       = 40;
  localparam int DM_W       = 41;
  localparam int DEN_W      = 32;
  localparam int QB_W       = 39;
  localparam int Q_W        = QB_W + 1;
  localparam int TRIG_MAX   = 40;
  localparam int ATAN_IDX_W = 6;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  // Register indexes on the configuration channel.
  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_MAX_ITER  = 1'b1;

  localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd107;
  localparam logic [ITER_W-1:0] ITER_RESET  = 6'd32;

  // Angle constants in units of 2^-30 degree, and the mean anomaly wrap in 2^-16.
  localparam longint ONE30     = 64'sd1 <<< 30;
  localparam longint DEG90     = 90 * ONE30;
  localparam longint DEG180    = 180 * ONE30;
  localparam longint DEG360    = 360 * ONE30;
  localparam longint FULL_M    = 360 * 65536;
  localparam longint HALF_M    = 180 * 65536;
  localparam longint E_MAX     = (64'sd1 <<< 38) - 1;
  localparam longint E_MIN     = -(64'sd1 <<< 38);
  localparam longint INV_GAIN  = 64'sd667681662976;
  localparam logic [Q_W-1:0] Q_CAP = Q_W'(64'd1 << 39);

  typedef longint atan_arr_t [TRIG_MAX];

  // Sequencer states of the solver.
  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_WFIX, S_TPREP, S_TZ1, S_TZ2, S_TZ3, S_CORD,
    S_ED1, S_ED2, S_ED3, S_ED4, S_DEN1, S_DEN2, S_DIVW, S_OUT
  } state_t;

  // Unsigned shift-and-subtract quotient, used only while building tables.
  function automatic longint unsigned cdiv(input longint unsigned num,
                                           input longint unsigned dvs);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= dvs) begin
        rem    = rem - dvs;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Arctangent of 2^-i in units of 2^-60 radian, by the alternating series.
  function automatic longint atan_inv_pow2(input int i);
    longint unsigned p;
    longint unsigned k;
    longint t;
    longint sum;
    p   = (64'd1 << 60) >> i;
    k   = 0;
    sum = 0;
    while (p != 0) begin
      t   = longint'(cdiv(p, 2 * k + 1));
      sum = k[0] ? sum - t : sum + t;
      p   = p >> (2 * i);
      k   = k + 1;
    end
    return sum;
  endfunction

  // Arctangent of 1/5 in units of 2^-60 radian.
  function automatic longint atan_inv5();
    longint unsigned p;
    longint unsigned k;
    longint t;
    longint sum;
    p   = (64'd1 << 60) / 5;
    k   = 0;
    sum = 0;
    while (p != 0) begin
      t   = longint'(cdiv(p, 2 * k + 1));
      sum = k[0] ? sum - t : sum + t;
      p   = cdiv(cdiv(p, 64'd5), 64'd5);
      k   = k + 1;
    end
    return sum;
  endfunction

  // Arctangent of 1/239 in units of 2^-60 radian.
  function automatic longint atan_inv239();
    longint unsigned p;
    longint unsigned k;
    longint t;
    longint sum;
    p   = (64'd1 << 60) / 239;
    k   = 0;
    sum = 0;
    while (p != 0) begin
      t   = longint'(cdiv(p, 2 * k + 1));
      sum = k[0] ? sum - t : sum + t;
      p   = cdiv(cdiv(p, 64'd239), 64'd239);
      k   = k + 1;
    end
    return sum;
  endfunction

  // Pi over four by Machin's formula, then the derived scale factors.
  localparam longint PI4      = 4 * atan_inv5() - atan_inv239();
  localparam longint PIQ      = 4 * PI4;
  localparam longint PIH      = PIQ >>> 30;
  localparam longint RAD_INT  = PIQ / DEG180;
  localparam longint RAD_FRAC = ((PIQ % DEG180) <<< 24) / DEG180;
  localparam longint K24      = ((64'sd180 <<< 54) + PIH / 2) / PIH;

  // Rotation angle table; entry zero is 45 degrees.
  function automatic atan_arr_t atan_table();
    atan_arr_t tab;
    for (int i = 0; i < TRIG_MAX; i++) begin
      if (i == 0) tab[i] = PI4;
      else        tab[i] = atan_inv_pow2(i);
    end
    return tab;
  endfunction

endpackage

// File: rtl/kes_cordic.sv
`timescale 1ns / 1ps
// Iterative rotation CORDIC: one micro-rotation per cycle, gives sine and cosine.
module kes_cordic #(
  parameter int TRIG_STAGES = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [kes_pkg::Z_W-1:0]    z0,
  output logic                              done,
  output logic signed [kes_pkg::TRIG_W-1:0] sin_o,
  output logic signed [kes_pkg::TRIG_W-1:0] cos_o
);

  localparam kes_pkg::atan_arr_t ATAN_TAB = kes_pkg::atan_table();
  localparam logic [kes_pkg::ATAN_IDX_W-1:0] LAST = kes_pkg::ATAN_IDX_W'(TRIG_STAGES - 1);

  logic signed [kes_pkg::XY_W-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys, xr, yr;
  logic signed [kes_pkg::Z_W-1:0]  z_r, z_nxt, atan_v;
  logic [kes_pkg::ATAN_IDX_W-1:0]  cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt, done_r, done_nxt;

  // One rotation step toward zero residual angle.
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    xs       = x_r >>> cnt_r;
    ys       = y_r >>> cnt_r;
    atan_v   = ATAN_TAB[cnt_r];
    if (start) begin
      x_nxt    = kes_pkg::XY_W'(kes_pkg::INV_GAIN);
      y_nxt    = '0;
      z_nxt    = z0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_v;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_v;
      end
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    cnt_r <= cnt_nxt;
  end

  // Round half up to 2^-30 and clamp to the unit range.
  always_comb begin
    yr = (y_r + kes_pkg::XY_W'(512)) >>> 10;
    xr = (x_r + kes_pkg::XY_W'(512)) >>> 10;
    if (yr > kes_pkg::ONE30)       sin_o = kes_pkg::TRIG_W'(kes_pkg::ONE30);
    else if (yr < -kes_pkg::ONE30) sin_o = kes_pkg::TRIG_W'(-kes_pkg::ONE30);
    else                           sin_o = kes_pkg::TRIG_W'(yr);
    if (xr > kes_pkg::ONE30)       cos_o = kes_pkg::TRIG_W'(kes_pkg::ONE30);
    else if (xr < -kes_pkg::ONE30) cos_o = kes_pkg::TRIG_W'(-kes_pkg::ONE30);
    else                           cos_o = kes_pkg::TRIG_W'(xr);
  end

  assign done = done_r;

endmodule

// File: rtl/kes_div.sv
`timescale 1ns / 1ps
// Restoring divider for the Newton step: one quotient bit per cycle, capped at 2^39.
module kes_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [kes_pkg::DM_W-1:0]       mag,
  input  logic [kes_pkg::DEN_W-1:0]      den,
  output logic                           done,
  output logic [kes_pkg::Q_W-1:0]        q
);

  localparam logic [kes_pkg::ATAN_IDX_W-1:0] LAST = kes_pkg::ATAN_IDX_W'(kes_pkg::QB_W - 1);

  logic [kes_pkg::DEN_W-1:0]      rem_r, rem_nxt, den_r, den_nxt;
  logic [kes_pkg::QB_W-1:0]       nb_r, nb_nxt, qa_r, qa_nxt;
  logic [kes_pkg::ATAN_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt, done_r, done_nxt, cap_r, cap_nxt;
  logic [kes_pkg::DEN_W:0]        sh;

  // Remainder stays below the divisor, so each step is a 33-bit compare.
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    nb_nxt   = nb_r;
    qa_nxt   = qa_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    cap_nxt  = cap_r;
    done_nxt = 1'b0;
    sh       = {rem_r, nb_r[kes_pkg::QB_W-1]};
    if (start) begin
      den_nxt = den;
      if (mag >= {den, 9'b0}) begin
        cap_nxt  = 1'b1;
        done_nxt = 1'b1;
      end else begin
        cap_nxt  = 1'b0;
        rem_nxt  = kes_pkg::DEN_W'(mag >> 9);
        nb_nxt   = {mag[8:0], 30'b0};
        qa_nxt   = '0;
        cnt_nxt  = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      nb_nxt = {nb_r[kes_pkg::QB_W-2:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = kes_pkg::DEN_W'(sh - {1'b0, den_r});
        qa_nxt  = {qa_r[kes_pkg::QB_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[kes_pkg::DEN_W-1:0];
        qa_nxt  = {qa_r[kes_pkg::QB_W-2:0], 1'b0};
      end
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    nb_r  <= nb_nxt;
    qa_r  <= qa_nxt;
    cnt_r <= cnt_nxt;
    cap_r <= cap_nxt;
  end

  assign done = done_r;
  assign q    = cap_r ? kes_pkg::Q_CAP : {1'b0, qa_r};

endmodule

// File: rtl/kepler_equation_solver_unit.sv
`timescale 1ns / 1ps
// From acceptance to out_tvalid: an initial CORDIC pass, then N Newton steps, each paced by
// the iterative CORDIC (one rotation a cycle) and the bit-serial divider (39 quotient bits);
// a step that saturates finishes its division sooner.
// Throughput: one word at a time; in_tready is low from acceptance until the result is taken.
// Reset (synchronous, rst_n low) returns to idle and loads tolerance 107, iteration limit 32.
// Kepler equation solver top level: sequencer, shared multiplier and configuration registers.
module kepler_equation_solver_unit #(
  parameter int TRIG_STAGES = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [kes_pkg::IN_DATA_W-1:0]      in_tdata,   // eccentricity[29:0], mean_anomaly[61:30]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [kes_pkg::OUT_DATA_W-1:0]     out_tdata,  // eccentric_anomaly[38:0],
                                                         // iterations[44:39], converged[45]
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [kes_pkg::TOL_W-1:0]          cfg_data
);

  localparam int ANG_W_EXT = kes_pkg::ANG_W + 3;

  kes_pkg::state_t state_r, state_nxt;

  logic [kes_pkg::TOL_W-1:0]              tol_r, tol_nxt;
  logic [kes_pkg::ITER_W-1:0]             maxit_r, maxit_nxt, n_r, n_nxt, lim, n_inc;
  logic [kes_pkg::ECC_W-1:0]              e_r, e_nxt, tl_r, tl_nxt;
  logic [kes_pkg::MA_W-1:0]               wa_r, wa_nxt, wsub, vin;
  logic [2:0]                             wk_r, wk_nxt;
  logic                                   vneg_r, vneg_nxt, negc_r, negc_nxt;
  logic                                   init_r, init_nxt, conv_r, conv_nxt;
  logic signed [kes_pkg::ANG_W-1:0]       m_r, m_nxt, be_r, be_nxt, ang_r, ang_nxt, e_new;
  logic signed [kes_pkg::RED_W-1:0]       rf_r, rf_nxt, ra, rb;
  logic signed [kes_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [kes_pkg::Z_W-1:0]         acc_r, acc_nxt, z0, edsum;
  logic signed [kes_pkg::TRIG_W-1:0]      s_r, s_nxt, c_r, c_nxt, cord_s, cord_c;
  logic signed [kes_pkg::ED_W-1:0]        edeg_r, edeg_nxt, ed;
  logic signed [kes_pkg::DM_W-1:0]        dm_r, dm_nxt;
  logic signed [kes_pkg::MUL_A_W-1:0]     mul_a;
  logic signed [kes_pkg::MUL_B_W-1:0]     mul_b;
  logic signed [kes_pkg::MA_W:0]          wr, wr2;
  logic signed [kes_pkg::ANG_W+2:0]       esum, qs;
  logic signed [kes_pkg::MA_W:0]          ecs;
  logic [kes_pkg::DM_W-1:0]               div_mag;
  logic [kes_pkg::DEN_W-1:0]              div_den;
  logic [kes_pkg::Q_W-1:0]                div_q;
  logic                                   cord_start, cord_done, div_start, div_done, conv_now;

  // Saturate an angle sum to the 39-bit result range.
  function automatic logic signed [kes_pkg::ANG_W-1:0] clamp_e(
    input logic signed [kes_pkg::ANG_W+2:0] v);
    if (v > kes_pkg::E_MAX)      return kes_pkg::ANG_W'(kes_pkg::E_MAX);
    else if (v < kes_pkg::E_MIN) return kes_pkg::ANG_W'(kes_pkg::E_MIN);
    else                         return kes_pkg::ANG_W'(v);
  endfunction

  kes_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .z0    (z0),
    .done  (cord_done),
    .sin_o (cord_s),
    .cos_o (cord_c)
  );

  kes_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (div_mag),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  assign lim   = (maxit_r == '0) ? kes_pkg::ITER_W'(1) : maxit_r;
  assign n_inc = n_r + 1'b1;

  // Sequencer, operand selection for the shared multiplier, and datapath updates.
  always_comb begin
    state_nxt  = state_r;
    tol_nxt    = tol_r;
    maxit_nxt  = maxit_r;
    e_nxt      = e_r;
    tl_nxt     = tl_r;
    wa_nxt     = wa_r;
    wk_nxt     = wk_r;
    vneg_nxt   = vneg_r;
    negc_nxt   = negc_r;
    init_nxt   = init_r;
    conv_nxt   = conv_r;
    n_nxt      = n_r;
    m_nxt      = m_r;
    be_nxt     = be_r;
    ang_nxt    = ang_r;
    rf_nxt     = rf_r;
    acc_nxt    = acc_r;
    s_nxt      = s_r;
    c_nxt      = c_r;
    edeg_nxt   = edeg_r;
    dm_nxt     = dm_r;
    mul_a      = '0;
    mul_b      = '0;
    z0         = '0;
    cord_start = 1'b0;
    div_start  = 1'b0;
    div_mag    = '0;
    div_den    = '0;
    vin        = in_tdata[61:30];
    wsub       = kes_pkg::MA_W'(kes_pkg::FULL_M) << wk_r;
    wr         = vneg_r ? -$signed({1'b0, wa_r}) : $signed({1'b0, wa_r});
    wr2        = wr;
    ra         = kes_pkg::RED_W'(ang_r);
    rb         = ra;
    edsum      = acc_r + kes_pkg::Z_W'(prod_r >>> 30) + kes_pkg::Z_W'(64'sd8388608);
    ed         = kes_pkg::ED_W'(edsum >>> 24);
    esum       = (ANG_W_EXT'(m_r)) + (ANG_W_EXT'(ed));
    ecs        = (kes_pkg::MA_W + 1)'(prod_r >>> 30);
    qs         = $signed({2'b00, div_q});
    conv_now   = (div_q <= kes_pkg::Q_W'(tol_r));
    e_new      = clamp_e(ANG_W_EXT'(be_r) + (dm_r[kes_pkg::DM_W-1] ? -qs : qs));

    // Configuration writes are always taken.
    if (cfg_valid) begin
      unique case (cfg_index)
        kes_pkg::CFG_TOLERANCE: tol_nxt   = cfg_data;
        kes_pkg::CFG_MAX_ITER:  maxit_nxt = cfg_data[kes_pkg::ITER_W-1:0];
        default:                tol_nxt   = tol_r;
      endcase
    end

    unique case (state_r)
      kes_pkg::S_IDLE: begin
        if (in_tvalid) begin
          e_nxt     = in_tdata[kes_pkg::ECC_W-1:0];
          vneg_nxt  = vin[kes_pkg::MA_W-1];
          wa_nxt    = vin[kes_pkg::MA_W-1] ? (kes_pkg::MA_W'(0) - vin) : vin;
          wk_nxt    = 3'd6;
          state_nxt = kes_pkg::S_WRAP;
        end
      end
      // Remove whole turns from |M|, one power-of-two multiple per cycle.
      kes_pkg::S_WRAP: begin
        if (wa_r >= wsub) wa_nxt = wa_r - wsub;
        wk_nxt = wk_r - 1'b1;
        if (wk_r == 3'd0) state_nxt = kes_pkg::S_WFIX;
      end
      kes_pkg::S_WFIX: begin
        if (wr < -kes_pkg::HALF_M)     wr2 = (kes_pkg::MA_W + 1)'(wr + kes_pkg::FULL_M);
        else if (wr > kes_pkg::HALF_M) wr2 = (kes_pkg::MA_W + 1)'(wr - kes_pkg::FULL_M);
        m_nxt     = kes_pkg::ANG_W'(wr2) <<< 14;
        ang_nxt   = kes_pkg::ANG_W'(wr2) <<< 14;
        init_nxt  = 1'b1;
        n_nxt     = '0;
        state_nxt = kes_pkg::S_TPREP;
      end
      // Reduce to one turn, then fold into the right half plane.
      kes_pkg::S_TPREP: begin
        if (ra > kes_pkg::DEG180)       rb = kes_pkg::RED_W'(ra - kes_pkg::DEG360);
        else if (ra < -kes_pkg::DEG180) rb = kes_pkg::RED_W'(ra + kes_pkg::DEG360);
        if (rb > kes_pkg::DEG90) begin
          rf_nxt   = kes_pkg::RED_W'(kes_pkg::DEG180 - rb);
          negc_nxt = 1'b1;
        end else if (rb < -kes_pkg::DEG90) begin
          rf_nxt   = kes_pkg::RED_W'(-kes_pkg::DEG180 - rb);
          negc_nxt = 1'b1;
        end else begin
          rf_nxt   = rb;
          negc_nxt = 1'b0;
        end
        state_nxt = kes_pkg::S_TZ1;
      end
      // Degrees to radians: integer factor, then the fractional factor.
      kes_pkg::S_TZ1: begin
        mul_a     = rf_r;
        mul_b     = kes_pkg::MUL_B_W'(kes_pkg::RAD_INT);
        state_nxt = kes_pkg::S_TZ2;
      end
      kes_pkg::S_TZ2: begin
        acc_nxt   = kes_pkg::Z_W'(prod_r);
        mul_a     = rf_r;
        mul_b     = kes_pkg::MUL_B_W'(kes_pkg::RAD_FRAC);
        state_nxt = kes_pkg::S_TZ3;
      end
      kes_pkg::S_TZ3: begin
        z0         = acc_r + kes_pkg::Z_W'(prod_r >>> 24);
        cord_start = 1'b1;
        state_nxt  = kes_pkg::S_CORD;
      end
      kes_pkg::S_CORD: begin
        if (cord_done) begin
          s_nxt     = cord_s;
          c_nxt     = negc_r ? -cord_c : cord_c;
          state_nxt = kes_pkg::S_ED1;
        end
      end
      // e*sin scaled to degrees: split product, two multiplies by 180/pi.
      kes_pkg::S_ED1: begin
        mul_a     = kes_pkg::MUL_A_W'($signed({1'b0, e_r}));
        mul_b     = s_r;
        state_nxt = kes_pkg::S_ED2;
      end
      kes_pkg::S_ED2: begin
        tl_nxt    = prod_r[kes_pkg::ECC_W-1:0];
        mul_a     = kes_pkg::MUL_A_W'(prod_r >>> 30);
        mul_b     = kes_pkg::MUL_B_W'(kes_pkg::K24);
        state_nxt = kes_pkg::S_ED3;
      end
      kes_pkg::S_ED3: begin
        acc_nxt   = kes_pkg::Z_W'(prod_r);
        mul_a     = kes_pkg::MUL_A_W'($signed({1'b0, tl_r}));
        mul_b     = kes_pkg::MUL_B_W'(kes_pkg::K24);
        state_nxt = kes_pkg::S_ED4;
      end
      kes_pkg::S_ED4: begin
        if (init_r) begin
          be_nxt    = clamp_e(esum);
          ang_nxt   = clamp_e(esum);
          init_nxt  = 1'b0;
          state_nxt = kes_pkg::S_TPREP;
        end else begin
          edeg_nxt  = ed;
          state_nxt = kes_pkg::S_DEN1;
        end
      end
      // Residual and e*cos for the denominator.
      kes_pkg::S_DEN1: begin
        mul_a     = kes_pkg::MUL_A_W'($signed({1'b0, e_r}));
        mul_b     = c_r;
        dm_nxt    = kes_pkg::DM_W'(m_r) - kes_pkg::DM_W'(be_r) + kes_pkg::DM_W'(edeg_r);
        state_nxt = kes_pkg::S_DEN2;
      end
      kes_pkg::S_DEN2: begin
        div_den   = kes_pkg::DEN_W'(kes_pkg::ONE30 - ecs);
        div_mag   = dm_r[kes_pkg::DM_W-1] ? kes_pkg::DM_W'(-dm_r) : kes_pkg::DM_W'(dm_r);
        div_start = 1'b1;
        state_nxt = kes_pkg::S_DIVW;
      end
      // Apply the step and test for convergence or the iteration limit.
      kes_pkg::S_DIVW: begin
        if (div_done) begin
          be_nxt   = e_new;
          ang_nxt  = e_new;
          n_nxt    = n_inc;
          conv_nxt = conv_now;
          if (conv_now || n_inc >= lim) state_nxt = kes_pkg::S_OUT;
          else                          state_nxt = kes_pkg::S_TPREP;
        end
      end
      kes_pkg::S_OUT: begin
        if (out_tready) state_nxt = kes_pkg::S_IDLE;
      end
      default: state_nxt = kes_pkg::S_IDLE;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kes_pkg::S_IDLE;
      tol_r   <= kes_pkg::TOL_RESET;
      maxit_r <= kes_pkg::ITER_RESET;
    end else begin
      state_r <= state_nxt;
      tol_r   <= tol_nxt;
      maxit_r <= maxit_nxt;
    end
    e_r    <= e_nxt;
    tl_r   <= tl_nxt;
    wa_r   <= wa_nxt;
    wk_r   <= wk_nxt;
    vneg_r <= vneg_nxt;
    negc_r <= negc_nxt;
    init_r <= init_nxt;
    conv_r <= conv_nxt;
    n_r    <= n_nxt;
    m_r    <= m_nxt;
    be_r   <= be_nxt;
    ang_r  <= ang_nxt;
    rf_r   <= rf_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    s_r    <= s_nxt;
    c_r    <= c_nxt;
    edeg_r <= edeg_nxt;
    dm_r   <= dm_nxt;
  end

  // Handshakes and result word.
  assign in_tready  = (state_r == kes_pkg::S_IDLE);
  assign out_tvalid = (state_r == kes_pkg::S_OUT);
  assign cfg_ready  = 1'b1;
  assign out_tdata  = {2'b00, conv_r, n_r, be_r};

  // The block never takes a word while a result is pending.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  // Every result reports at least one Newton step.
  a_iter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (n_r != '0))
    else $error("result with zero iterations");

  // A result without convergence must have used the full step budget.
  a_limit_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !conv_r) |-> (n_r == lim))
    else $error("non-converged result before the iteration limit");

  // The divider is never started with a zero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (div_den != '0))
    else $error("divider started with zero denominator");

endmodule
